// ===== rtl/core/lbpdt_pkg.sv =====
package lbpdt_pkg;
  localparam int NumWidth = 32;
  localparam int CapWidth = 64;

  typedef struct packed {
    logic [NumWidth-1:0] number;
    logic [NumWidth-1:0] index;
    logic [NumWidth-1:0] prime_base;
    logic [CapWidth-1:0] count_cap;
  } in_item_t;

  typedef struct packed {
    logic                not_divisible;
    logic [CapWidth-1:0] subindex_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_MUL_LO,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                start;
    logic [NumWidth-1:0] dividend;
    logic [NumWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic [NumWidth-1:0] quotient;
    logic [NumWidth-1:0] remainder;
  } div_rsp_t;
endpackage

// ===== rtl/core/lbpdt_if.sv =====
interface lbpdt_in_if (input logic clk);
  logic               valid;
  logic               ready;
  lbpdt_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lbpdt_out_if (input logic clk);
  logic                valid;
  logic                ready;
  lbpdt_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lbpdt_cell.sv =====
module lbpdt_cell (
  input  logic [lbpdt_pkg::NumWidth-1:0]      rem_in,
  input  logic                                bit_in,
  input  logic [lbpdt_pkg::NumWidth-1:0]      divisor,
  output logic [lbpdt_pkg::NumWidth-1:0]      rem_out,
  output logic                                q_out
);
  logic [lbpdt_pkg::NumWidth:0] trial;
  logic [lbpdt_pkg::NumWidth:0] shifted;

  always_comb begin
    shifted = {rem_in, bit_in};
    trial = shifted - {1'b0, divisor};
    if (!trial[lbpdt_pkg::NumWidth]) begin
      rem_out = trial[lbpdt_pkg::NumWidth-1:0];
      q_out = 1'b1;
    end else begin
      rem_out = shifted[lbpdt_pkg::NumWidth-1:0];
      q_out = 1'b0;
    end
  end
endmodule

// ===== rtl/core/lbpdt_divider.sv =====
module lbpdt_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  lbpdt_pkg::div_req_t  req,
  output lbpdt_pkg::div_rsp_t  rsp
);
  localparam int W = lbpdt_pkg::NumWidth;
  localparam int Cells = 4;
  localparam int Rounds = W / Cells;
  localparam int RW = $clog2(Rounds + 1);

  logic [W-1:0] rem [Cells+1];
  logic [Cells-1:0] qbit;
  logic [Cells-1:0] qrev;
  logic [W-1:0] dividend;
  logic [W-1:0] quotient;
  logic [W-1:0] divisor;
  logic [W-1:0] remainder;
  logic [RW-1:0] round;
  logic busy;

  assign rem[0] = remainder;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    lbpdt_cell u_cell (
      .rem_in(rem[g]), .bit_in(dividend[W-1-g]), .divisor(divisor),
      .rem_out(rem[g+1]), .q_out(qbit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      round <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      round <= RW'(Rounds);
    end else if (busy) begin
      round <= round - 1'b1;
      if (round == RW'(1)) busy <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < Cells; i++) qrev[Cells-1-i] = qbit[i];
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= req.dividend;
      divisor <= req.divisor;
      remainder <= '0;
      quotient <= '0;
    end else if (busy) begin
      dividend <= dividend << Cells;
      remainder <= rem[Cells];
      quotient <= {quotient[W-Cells-1:0], qrev};
    end
  end

  assign rsp.busy = busy | req.start;
  assign rsp.quotient = quotient;
  assign rsp.remainder = remainder;
endmodule

// ===== rtl/core/lucas_base_p_digit_test.sv =====
// channel  dir  payload
// in       in   number, index, prime_base, count_cap
// out      out  not_divisible, subindex_count
// Each digit takes two divides (number, index) by the base through a chain of
// four restoring-division cells, then the multiply states ST_MUL_LO and ST_MUL.
// An item runs one such digit step per base-p digit of the larger operand,
// between an accept and a done step, one item at a time; base 2 gives the most digits.
// Reset idles the controller and empties the output.
// A result waits in the output register; the done step holds until that register is free.
module lucas_base_p_digit_test (
  input logic clk,
  input logic rst,
  lbpdt_in_if.sink    in,
  lbpdt_out_if.source out
);
  localparam int W = lbpdt_pkg::NumWidth;
  localparam int C = lbpdt_pkg::CapWidth;
  localparam int H = C / 2;

  lbpdt_pkg::state_t state, state_next;
  lbpdt_pkg::div_req_t req;
  lbpdt_pkg::div_rsp_t rsp;

  logic [W-1:0] n, k, p, nq, nd;
  logic [C-1:0] cap, count;
  logic dom, side, capped, nz_seen;
  logic out_valid;
  logic done_go;
  logic [W-1:0] factor;
  logic [H-1:0] mul_a;
  logic [H+W-1:0] mul_out;
  logic [H+W-1:0] prod_lo;
  logic [C+W-1:0] prod;

  lbpdt_divider u_div (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  assign in.ready = (state == lbpdt_pkg::ST_IDLE);
  assign out.valid = out_valid;
  assign done_go = (state == lbpdt_pkg::ST_DONE) && (!out_valid || out.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      lbpdt_pkg::ST_IDLE: if (in.valid && in.ready) state_next = lbpdt_pkg::ST_DIV;
      lbpdt_pkg::ST_DIV: state_next = lbpdt_pkg::ST_DIGIT;
      lbpdt_pkg::ST_DIGIT: if (!rsp.busy) state_next = side ? lbpdt_pkg::ST_MUL_LO
                                                            : lbpdt_pkg::ST_DIV;
      lbpdt_pkg::ST_MUL_LO: state_next = lbpdt_pkg::ST_MUL;
      lbpdt_pkg::ST_MUL:
        if (n == '0 && k == '0) state_next = lbpdt_pkg::ST_DONE;
        else state_next = lbpdt_pkg::ST_DIV;
      lbpdt_pkg::ST_DONE: if (done_go) state_next = lbpdt_pkg::ST_IDLE;
      default: state_next = lbpdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req.start = (state == lbpdt_pkg::ST_DIV);
    req.dividend = side ? k : n;
    req.divisor = p;
  end

  assign factor = nd + W'(1);
  assign mul_a = (state == lbpdt_pkg::ST_MUL_LO) ? count[H-1:0] : count[C-1:H];
  assign mul_out = (H+W)'(mul_a) * (H+W)'(factor);
  assign prod = {mul_out, {H{1'b0}}} + (C+W)'(prod_lo);

  always_ff @(posedge clk) begin
    if (rst) state <= lbpdt_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (done_go) out_valid <= 1'b1;
    else if (out.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lbpdt_pkg::ST_IDLE: begin
        n <= in.data.number;
        k <= in.data.index;
        p <= (in.data.prime_base < W'(2)) ? W'(2) : in.data.prime_base;
        cap <= in.data.count_cap;
        count <= C'(1);
        dom <= 1'b1;
        side <= 1'b0;
        capped <= (in.data.count_cap <= C'(1));
        nz_seen <= 1'b0;
      end
      lbpdt_pkg::ST_DIGIT: if (!rsp.busy) begin
        if (!side) begin
          nd <= rsp.remainder;
          nq <= rsp.quotient;
        end else begin
          if (rsp.remainder > nd) dom <= 1'b0;
          k <= rsp.quotient;
          n <= nq;
        end
        side <= !side;
      end
      lbpdt_pkg::ST_MUL_LO: prod_lo <= mul_out;
      lbpdt_pkg::ST_MUL: begin
        if (!nz_seen) begin
          if (!capped) begin
            if (prod[C+W-1:C] != '0 || prod[C-1:0] >= cap) capped <= 1'b1;
            else count <= prod[C-1:0];
          end
        end
        if (n == '0) nz_seen <= 1'b1;
      end
      lbpdt_pkg::ST_DONE: if (done_go) begin
        out.data.not_divisible <= dom;
        out.data.subindex_count <= capped ? cap : count;
      end
      default: ;
    endcase
  end
endmodule

// ===== rtl/core/lbpdt_checker.sv =====
module lbpdt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("out dropped");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> (!in_ready) [*20]) else $error("accept too soon");
  a_accept_clears_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("out after reset");
endmodule

bind lucas_base_p_digit_test lbpdt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready)
);

// ===== sim/lucas_base_p_digit_test_test.sv =====
module lucas_base_p_digit_test_test;
  import lbpdt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  lbpdt_in_if  in_ch (clk);
  lbpdt_out_if out_ch (clk);

  lucas_base_p_digit_test u_top (
    .clk(clk),
    .rst(rst),
    .in (in_ch.sink),
    .out(out_ch.source)
  );

  out_item_t expected_q[$];
  int        err_count = 0;
  int        cycle_count = 0;
  bit        hold_off = 1'b0;
  int        burst_left = 0;

  localparam int CycleLimit = 2000000;

  function automatic out_item_t lucas_predict(in_item_t it);
    out_item_t   r;
    logic [63:0] n, k, p, cap, cnt, f;
    bit          dom, sat;
    n = 64'(it.number);
    k = 64'(it.index);
    p = 64'(it.prime_base);
    cap = it.count_cap;
    if (p < 2) p = 2;
    dom = 1'b1;
    while (n != 0 || k != 0) begin
      if (k % p > n % p) dom = 1'b0;
      n = n / p;
      k = k / p;
    end
    n = 64'(it.number);
    cnt = 1;
    sat = 1'b0;
    do begin
      f = (n % p) + 1;
      if (cnt > cap / f) sat = 1'b1;
      else begin
        cnt = cnt * f;
        if (cnt >= cap) sat = 1'b1;
      end
      n = n / p;
    end while (n != 0 && !sat);
    r.not_divisible = dom;
    r.subindex_count = sat ? cap : cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_count++;
  endtask

  task automatic send_item(in_item_t it);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q = {expected_q, lucas_predict(it)};
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) in_ch.valid <= 1'b0;
  endtask

  task automatic send_fields(logic [31:0] n, logic [31:0] k, logic [31:0] p,
                             logic [63:0] cap);
    in_item_t it;
    it.number = n;
    it.index = k;
    it.prime_base = p;
    it.count_cap = cap;
    send_item(it);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 30);
      1: return $urandom_range(0, 5000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_base();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return 32'hFFFF_FFFF - $urandom_range(0, 4);
      2: return $urandom;
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  function automatic logic [63:0] rand_cap();
    case ($urandom_range(0, 4))
      0: return 64'($urandom_range(0, 3));
      1: return 64'($urandom_range(0, 2000));
      2: return {$urandom, $urandom};
      default: return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  task automatic test_directed();
    send_fields(0, 0, 3, 64'd10);
    send_fields(0, 0, 3, 64'd0);
    send_fields(0, 5, 3, 64'd100);
    send_fields(10, 30, 3, 64'd100);
    send_fields(10, 3, 0, 64'd100);
    send_fields(10, 3, 1, 64'd100);
    send_fields(32'hFFFF_FFFF, 32'hFFFF_FFFF, 2, 64'hFFFF_FFFF_FFFF_FFFF);
    send_fields(32'hFFFF_FFFF, 0, 2, 64'hFFFF_FFFF_FFFF_FFFF);
    send_fields(32'hFFFF_FFFF, 32'h5555_5555, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_fields(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd7);
    send_fields(80, 26, 3, 64'd4);
    send_fields(80, 26, 3, 64'd5);
    send_fields(26, 26, 3, 64'd27);
    send_fields(26, 26, 3, 64'd28);
    send_fields(100, 7, 7, 64'd1);
    send_fields(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 64'h8000_0000_0000_0000);
    send_fields(32'd65536, 32'd1, 32'd65537, 64'd3);
  endtask

  task automatic test_random(int count);
    logic [31:0] n, k;
    repeat (count) begin
      n = rand_word();
      k = ($urandom_range(0, 2) == 0) ? rand_word() : (n & $urandom);
      send_fields(n, k, rand_base(), rand_cap());
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      repeat (400) @(posedge clk);
      test_random(6);
    join_any
    hold_off = 1'b0;
    wait fork;
  endtask

  always @(negedge clk) begin
    if (rst || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 9) < 7) || (cycle_count[9:7] == 3'd2);
  end

  always @(posedge clk) begin
    out_item_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.data.not_divisible !== want.not_divisible)
          report_mismatch("not_divisible", 64'(out_ch.data.not_divisible),
                          64'(want.not_divisible));
        if (out_ch.data.subindex_count !== want.subindex_count)
          report_mismatch("subindex_count", out_ch.data.subindex_count,
                          want.subindex_count);
      end
    end
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random(380);
    if (burst_left != 0) in_ch.valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (2000) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== lucas_base_p_digit_test.f =====
rtl/core/lbpdt_pkg.sv
rtl/core/lbpdt_if.sv
rtl/core/lbpdt_cell.sv
rtl/core/lbpdt_divider.sv
rtl/core/lucas_base_p_digit_test.sv
rtl/core/lbpdt_checker.sv
sim/lucas_base_p_digit_test_test.sv
